[design/prs_pkg.sv]
// Package for the pick retry supervisor: command, error and register codes,
// and the packed payload types of the event and result channels.
// No dependencies.
package prs_pkg;

  localparam int CounterWidth = 32;
  localparam int StreakWidth  = 16;
  localparam int OutCntWidth  = 32;

  // command codes
  localparam logic [2:0] ACT_START      = 3'd0;
  localparam logic [2:0] ACT_STOP       = 3'd1;
  localparam logic [2:0] ACT_PICK       = 3'd2;
  localparam logic [2:0] ACT_ESTOP      = 3'd3;
  localparam logic [2:0] ACT_RECOVER    = 3'd4;
  localparam logic [2:0] ACT_RESET_SESS = 3'd5;
  localparam logic [2:0] ACT_AUTO_ON    = 3'd6;
  localparam logic [2:0] ACT_AUTO_OFF   = 3'd7;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_ALREADY     = 3'd1;
  localparam logic [2:0] ERR_IN_FAULT    = 3'd2;
  localparam logic [2:0] ERR_NOT_RUNNING = 3'd3;
  localparam logic [2:0] ERR_NO_MANAGER  = 3'd4;
  localparam logic [2:0] ERR_NOT_BOUND   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_RETRY       = 2'd0;
  localparam logic [1:0] REG_MANAGER_PRESENT = 2'd1;
  localparam logic [1:0] REG_DEVICES_BOUND   = 2'd2;

  localparam logic [7:0] MAX_RETRY_RESET = 8'd3;

  typedef struct packed {
    logic [2:0] action;
    logic       pick_success;
  } prs_in_t;

  typedef struct packed {
    logic [2:0]             cell_state;
    logic                   accepted;
    logic [2:0]             error_code;
    logic                   auto_on;
    logic                   state_changed;
    logic [StreakWidth-1:0] fail_streak_out;
    logic [OutCntWidth-1:0] attempts_out;
    logic [OutCntWidth-1:0] successes_out;
    logic [OutCntWidth-1:0] failures_out;
  } prs_out_t;

endpackage

[design/pick_retry_supervisor_fsm.sv]
// Pick retry supervisor: one command word in, one result word out.
// The result is valid in the cycle after acceptance and held until taken.
// Throughput: one command per cycle when the result is taken at once; the
// cell state, flag and counters are updated at the accepting edge.
// Reset (rst, synchronous): cell idle, auto flag and all counters cleared,
// max_retry 3, manager_present and devices_bound 0, no result pending.
module pick_retry_supervisor_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prs_pkg::prs_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prs_pkg::prs_out_t    out_data
);

  typedef enum logic [2:0] {
    IDLE     = 3'd0,
    RUNNING  = 3'd1,
    DEGRADED = 3'd2,
    STOPPED  = 3'd3,
    FAULT    = 3'd4
  } mode_t;

  localparam int CW = prs_pkg::CounterWidth;
  localparam int SW = prs_pkg::StreakWidth;

  mode_t           mode, mode_next;
  logic            auto_flag, auto_flag_next;
  logic [SW-1:0]   fail_streak, fail_streak_next;
  logic [CW-1:0]   attempt_total, attempt_total_next;
  logic [CW-1:0]   success_total, success_total_next;
  logic [CW-1:0]   failure_total, failure_total_next;
  logic [7:0]      max_retry;
  logic            manager_present;
  logic            devices_bound;
  logic [2:0]      err;
  logic            acc;
  logic            active;
  logic            in_fire;
  logic [SW-1:0]   streak_inc;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign active   = (mode == RUNNING) || (mode == DEGRADED);
  assign streak_inc = (fail_streak == '1) ? fail_streak : fail_streak + 1'b1;

  always_comb begin
    mode_next          = mode;
    auto_flag_next     = auto_flag;
    fail_streak_next   = fail_streak;
    attempt_total_next = attempt_total;
    success_total_next = success_total;
    failure_total_next = failure_total;
    err                = prs_pkg::ERR_NONE;
    acc                = 1'b1;
    case (in_data.action)
      prs_pkg::ACT_START: begin
        if (mode == RUNNING) begin
          err = prs_pkg::ERR_ALREADY;
        end else if (mode == FAULT) begin
          err = prs_pkg::ERR_IN_FAULT;
        end else begin
          mode_next = RUNNING;
        end
      end
      prs_pkg::ACT_STOP: begin
        if (active) begin
          auto_flag_next = 1'b0;
          mode_next      = STOPPED;
        end else begin
          err = prs_pkg::ERR_NOT_RUNNING;
        end
      end
      prs_pkg::ACT_PICK: begin
        if (active) begin
          attempt_total_next = (attempt_total == '1) ? attempt_total : attempt_total + 1'b1;
          if (in_data.pick_success) begin
            success_total_next = (success_total == '1) ? success_total
                                                       : success_total + 1'b1;
            fail_streak_next   = '0;
            mode_next          = RUNNING;
          end else begin
            failure_total_next = (failure_total == '1) ? failure_total
                                                       : failure_total + 1'b1;
            fail_streak_next   = streak_inc;
            if (streak_inc >= SW'(max_retry)) begin
              mode_next = DEGRADED;
            end
          end
        end
      end
      prs_pkg::ACT_ESTOP: begin
        auto_flag_next = 1'b0;
        mode_next      = FAULT;
      end
      prs_pkg::ACT_RECOVER: begin
        if (mode == FAULT) begin
          fail_streak_next = '0;
          mode_next        = IDLE;
        end else begin
          acc = 1'b0;
        end
      end
      prs_pkg::ACT_RESET_SESS: begin
        attempt_total_next = '0;
        success_total_next = '0;
        failure_total_next = '0;
        fail_streak_next   = '0;
        if (mode == STOPPED) begin
          mode_next = IDLE;
        end
      end
      prs_pkg::ACT_AUTO_ON: begin
        // run the start step first when idle or stopped; reject in fault
        if (!active && (mode == FAULT)) begin
          err = prs_pkg::ERR_IN_FAULT;
        end else begin
          if (!active) begin
            mode_next = RUNNING;
          end
          if (!manager_present) begin
            err = prs_pkg::ERR_NO_MANAGER;
          end else if (!devices_bound) begin
            err = prs_pkg::ERR_NOT_BOUND;
          end else begin
            auto_flag_next = 1'b1;
          end
        end
      end
      default: begin
        auto_flag_next = 1'b0;
      end
    endcase
    if (err != prs_pkg::ERR_NONE) begin
      acc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retry       <= prs_pkg::MAX_RETRY_RESET;
      manager_present <= 1'b0;
      devices_bound   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        prs_pkg::REG_MAX_RETRY:       max_retry       <= cfg_data;
        prs_pkg::REG_MANAGER_PRESENT: manager_present <= cfg_data[0];
        prs_pkg::REG_DEVICES_BOUND:   devices_bound   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= IDLE;
      auto_flag     <= 1'b0;
      fail_streak   <= '0;
      attempt_total <= '0;
      success_total <= '0;
      failure_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        mode          <= mode_next;
        auto_flag     <= auto_flag_next;
        fail_streak   <= fail_streak_next;
        attempt_total <= attempt_total_next;
        success_total <= success_total_next;
        failure_total <= failure_total_next;
        out_valid     <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word: no reset, loaded with the state the event leaves behind
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.cell_state      <= mode_next;
      out_data.accepted        <= acc;
      out_data.error_code      <= err;
      out_data.auto_on         <= auto_flag_next;
      out_data.state_changed   <= (mode_next != mode);
      out_data.fail_streak_out <= fail_streak_next;
      out_data.attempts_out    <= prs_pkg::OutCntWidth'(attempt_total_next);
      out_data.successes_out   <= prs_pkg::OutCntWidth'(success_total_next);
      out_data.failures_out    <= prs_pkg::OutCntWidth'(failure_total_next);
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted command produced no result");

  a_state_tracks_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cell_state == mode))
    else $error("reported cell state differs from held state");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (out_data.state_changed == (mode != $past(mode))))
    else $error("state_changed does not match the transition");

  a_estop_faults: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_data.action == prs_pkg::ACT_ESTOP))
      |=> ((mode == FAULT) && !auto_flag && out_data.accepted))
    else $error("emergency stop did not force fault");

  a_error_rejects: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !(out_data.accepted && (out_data.error_code != prs_pkg::ERR_NONE)))
    else $error("command reported accepted with an error code");

endmodule
